// ----- hw/rtl/stable_priority_work_queue_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Stable priority work queue assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_WORK_QUEUE_UNIT_DEFINES_SVH
`define STABLE_PRIORITY_WORK_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define SPWQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("spwq assertion failed");
// Checked at every edge, reset included.
`define SPWQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("spwq assertion failed");
`else
`define SPWQ_ASSERT(label, prop)
`define SPWQ_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- hw/rtl/spwq_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable priority work queue package
// Transaction types, entry type and cell control shared by the queue files.
// ----------------------------------------------------------------------------
package spwq_pkg;

  localparam int unsigned PriorityBits = 8;
  localparam int unsigned WordBits     = 32;
  localparam int unsigned OccBits      = 4;

  localparam logic OpEnqueue = 1'b0;
  localparam logic OpDequeue = 1'b1;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic [PriorityBits-1:0] priority_req;
    logic [WordBits-1:0]     handler;
    logic [WordBits-1:0]     argument;
  } req_t;

  typedef struct packed {
    logic                    status;
    logic [PriorityBits-1:0] out_priority;
    logic [WordBits-1:0]     out_handler;
    logic [WordBits-1:0]     out_argument;
    logic [OccBits-1:0]      occupancy;
  } rsp_t;

  typedef struct packed {
    logic                    valid;
    logic [PriorityBits-1:0] prio;
    logic [WordBits-1:0]     handler;
    logic [WordBits-1:0]     argument;
  } entry_t;

  // Broadcast to every cell; only set for a transaction that succeeds.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/spwq_cell.sv -----
// ----------------------------------------------------------------------------
// Stable priority work queue cell
// One slot of the sorted chain: holds, shifts in from either side, or loads.
// ----------------------------------------------------------------------------
module spwq_cell import spwq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     left_i,
  input  logic       left_gt_i,
  input  entry_t     right_i,
  output entry_t     entry_o,
  output logic       gt_o
);

  logic                    valid_q, valid_d;
  logic [PriorityBits-1:0] prio_q, prio_d;
  logic [WordBits-1:0]     handler_q, handler_d;
  logic [WordBits-1:0]     argument_q, argument_d;

  // Slot lies at or behind the insertion point.
  assign gt_o = !valid_q || (prio_q > new_i.prio);

  always_comb begin
    priority if (ctrl_i.enq && gt_o && !left_gt_i) begin
      valid_d    = 1'b1;
      prio_d     = new_i.prio;
      handler_d  = new_i.handler;
      argument_d = new_i.argument;
    end else if (ctrl_i.enq && gt_o) begin
      valid_d    = left_i.valid;
      prio_d     = left_i.prio;
      handler_d  = left_i.handler;
      argument_d = left_i.argument;
    end else if (ctrl_i.deq) begin
      valid_d    = right_i.valid;
      prio_d     = right_i.prio;
      handler_d  = right_i.handler;
      argument_d = right_i.argument;
    end else begin
      valid_d    = valid_q;
      prio_d     = prio_q;
      handler_d  = handler_q;
      argument_d = argument_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q     <= prio_d;
    handler_q  <= handler_d;
    argument_q <= argument_d;
  end

  assign entry_o = '{valid: valid_q, prio: prio_q, handler: handler_q, argument: argument_q};

endmodule

// ----- hw/rtl/stable_priority_work_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Stable priority work queue
// Bounded sorted queue; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (req_t)
//  out     | output    | out_valid_o/ out_ready_i| out_data_o (rsp_t)
//
// One transaction per cycle: every cell compares against the incoming
// priority and shifts or loads in the same cycle, so the chain update sets
// the rate. The response is registered and appears in the cycle after accept.
// A waiting response stalls input only when out_ready_i is low.
// Reset clears the cell valid bits and the fill count; no clearing pass.
// ----------------------------------------------------------------------------
`include "stable_priority_work_queue_unit_defines.svh"

module stable_priority_work_queue_unit import spwq_pkg::*; #(
  parameter int unsigned DEPTH = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t                cells [DEPTH];
  logic   [DEPTH-1:0]    gt;
  logic   [DEPTH-1:0]    valid_vec;
  entry_t                new_entry;
  entry_t                empty_entry;
  cell_ctrl_t            ctrl;
  logic                  in_acc;
  logic                  full, empty;
  logic   [CntW-1:0]     count_q, count_d;
  logic                  res_valid_q, res_valid_d;
  rsp_t                  res_q, res_d;

  // Response register parts the two sides; refill while it drains.
  assign in_ready_o = !res_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign full  = cells[DEPTH-1].valid;
  assign empty = !cells[0].valid;

  assign new_entry   = '{valid: 1'b1, prio: in_data_i.priority_req,
                         handler: in_data_i.handler, argument: in_data_i.argument};
  assign empty_entry = '{valid: 1'b0, prio: '0, handler: '0, argument: '0};

  assign ctrl.enq = in_acc && (in_data_i.opcode == OpEnqueue) && !full;
  assign ctrl.deq = in_acc && (in_data_i.opcode == OpDequeue) && !empty;

  // The chain: slot 0 is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_gt;
    if (i == 0) begin : g_head
      assign left_e  = empty_entry;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = cells[i-1];
      assign left_gt = gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = empty_entry;
    end else begin : g_body
      assign right_e = cells[i+1];
    end

    spwq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_i     (new_entry),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .entry_o   (cells[i]),
      .gt_o      (gt[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  // Fill count tracks the valid run for the occupancy field.
  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    res_d = '{status: StatusOk, out_priority: '0, out_handler: '0,
              out_argument: '0, occupancy: OccBits'(count_d)};
    if (in_data_i.opcode == OpEnqueue) begin
      if (full) begin
        res_d.status = StatusFail;
      end
    end else begin
      if (empty) begin
        res_d.status = StatusFail;
      end else begin
        res_d.out_priority = cells[0].prio;
        res_d.out_handler  = cells[0].handler;
        res_d.out_argument = cells[0].argument;
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (in_acc) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // Checks
  `SPWQ_ASSERT(a_count_matches, count_q == CntW'($countones(valid_vec)))
  `SPWQ_ASSERT(a_valid_contiguous, (valid_vec & (valid_vec + DEPTH'(1))) == '0)
  `SPWQ_ASSERT(a_deq_shrinks, ctrl.deq |=> count_q == $past(count_q) - CntW'(1))
  `SPWQ_ASSERT(a_enq_grows, ctrl.enq |=> count_q == $past(count_q) + CntW'(1))

endmodule
